[rtl/dphr_pkg.sv]
`timescale 1ns / 1ps
package dphr_pkg;

   localparam int TABLE_SLOTS_DEF = 4096;
   localparam int MAX_BASES       = 32;
   localparam int KEY_W           = 64;
   localparam int HASH_W          = 32;
   localparam int LEN_W           = 6;
   localparam int SLOT_W          = 12;
   localparam int STATUS_W        = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED,
      ST_DUPLICATE,
      ST_FOUND,
      ST_NOT_FOUND,
      ST_FULL,
      ST_BAD
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_SCAN_READ,
      S_SCAN_CHECK,
      S_LINK,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_CUR,
      SEL_SCAN
   } slot_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         clr_write;
      logic         accept;
      logic         rd_cur;
      logic         rd_scan;
      logic         cur_from_link;
      logic         save_tail;
      logic         scan_init;
      logic         scan_next;
      logic         wr_new_cur;
      logic         wr_new_scan;
      logic         wr_link;
      logic         res_load;
      status_type   res_status;
      slot_sel_type res_sel;
      logic         rsp_push;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic req_bad;
      logic cmd_query;
      logic rd_used;
      logic rd_match;
      logic rd_link_zero;
      logic scan_end;
      logic rsp_free;
   } dp_stat_type;

   // fold the low 32 key bits into the hash
   function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_W-1:0] key);
      logic [HASH_W-1:0] h;
      h = key[HASH_W-1:0];
      return h + (h >> 11) + (h >> 20);
   endfunction

endpackage

[rtl/dphr_ctrl.sv]
`timescale 1ns / 1ps
module dphr_ctrl
   import dphr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = ST_BAD;
      cmd.res_sel    = SEL_ZERO;
      req_ready      = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.req_bad) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_BAD;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (!stat.rd_used) begin
               cmd.res_load = 1'b1;
               if (stat.cmd_query) begin
                  cmd.res_status = ST_NOT_FOUND;
               end else begin
                  cmd.wr_new_cur = 1'b1;
                  cmd.res_status = ST_INSERTED;
                  cmd.res_sel    = SEL_CUR;
               end
               state_in = S_RESP;
            end else if (stat.rd_match) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = stat.cmd_query ? ST_FOUND : ST_DUPLICATE;
               cmd.res_sel    = SEL_CUR;
               state_in       = S_RESP;
            end else if (!stat.rd_link_zero) begin
               cmd.cur_from_link = 1'b1;
               state_in          = S_READ;
            end else if (stat.cmd_query) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_RESP;
            end else begin
               cmd.save_tail = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN_READ;
            end
         end
         S_SCAN_READ: begin
            if (stat.scan_end) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = S_SCAN_CHECK;
            end
         end
         S_SCAN_CHECK: begin
            if (!stat.rd_used) begin
               cmd.wr_new_scan = 1'b1;
               cmd.res_load    = 1'b1;
               cmd.res_status  = ST_INSERTED;
               cmd.res_sel     = SEL_SCAN;
               state_in        = S_LINK;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_READ;
            end
         end
         S_LINK: begin
            cmd.wr_link = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/dphr_datapath.sv]
`timescale 1ns / 1ps
module dphr_datapath
   import dphr_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_cmd,
   input  logic [KEY_W-1:0]      req_pattern_bases,
   input  logic [LEN_W-1:0]      req_pattern_length,
   input  logic                  req_bad_base,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   input  ctl_cmd_type           cmd,
   output dp_stat_type           stat
);

   localparam int AW     = $clog2(TABLE_SLOTS);
   localparam int LEN_LO = KEY_W;
   localparam int HSH_LO = KEY_W + LEN_W;
   localparam int LNK_LO = HSH_LO + HASH_W;
   localparam int WW     = LNK_LO + AW + 1;

   logic [WW-1:0] mem [TABLE_SLOTS];

   logic [WW-1:0]       rd_ff, tail_ff;
   logic [AW-1:0]       cur_ff, tail_addr_ff, clr_ff, res_slot_ff;
   logic [AW:0]         scan_ff, fss_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [HASH_W-1:0]   hash_ff;
   logic                query_ff;
   status_type          res_status_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic [KEY_W-1:0]    key_in;
   logic [HASH_W-1:0]   hash_in;
   logic [6:0]          mask_shift;
   logic                we;
   logic [AW-1:0]       waddr, raddr;
   logic [WW-1:0]       wdata, new_word, link_word;
   logic [AW-1:0]       res_slot_in;
   logic [AW+SLOT_W-1:0] slot_wide;

   // mask the key to its length and fold it
   always_comb begin
      mask_shift = {req_pattern_length, 1'b0};
      if (req_pattern_length >= LEN_W'(32)) begin
         key_in = req_pattern_bases;
      end else begin
         key_in = req_pattern_bases & ~({KEY_W{1'b1}} << mask_shift);
      end
      hash_in = fold_hash(key_in);
   end

   // build the words to store
   always_comb begin
      new_word                       = rd_ff;
      new_word[WW-1]                 = 1'b1;
      new_word[LNK_LO-1:HSH_LO]      = hash_ff;
      new_word[HSH_LO-1:LEN_LO]      = len_ff;
      new_word[LEN_LO-1:0]           = key_ff;
      link_word                      = tail_ff;
      link_word[LNK_LO+AW-1:LNK_LO]  = scan_ff[AW-1:0];
   end

   // pick the write port source
   always_comb begin
      we    = 1'b1;
      waddr = cur_ff;
      wdata = new_word;
      if (cmd.clr_write) begin
         waddr = clr_ff;
         wdata = '0;
      end else if (cmd.wr_new_cur) begin
         waddr = cur_ff;
      end else if (cmd.wr_new_scan) begin
         waddr = scan_ff[AW-1:0];
      end else if (cmd.wr_link) begin
         waddr = tail_addr_ff;
         wdata = link_word;
      end else begin
         we = 1'b0;
      end
      raddr = cmd.rd_scan ? scan_ff[AW-1:0] : cur_ff;
   end

   // slot store
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (cmd.rd_cur || cmd.rd_scan) rd_ff <= mem[raddr];
   end

   // result slot selection
   always_comb begin
      case (cmd.res_sel)
         SEL_CUR:  res_slot_in = cur_ff;
         SEL_SCAN: res_slot_in = scan_ff[AW-1:0];
         default:  res_slot_in = '0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         fss_ff       <= {{AW{1'b0}}, 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write) clr_ff <= clr_ff + 1'b1;
         if (cmd.wr_new_scan) fss_ff <= scan_ff + 1'b1;
         if (cmd.rsp_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff   <= key_in;
         len_ff   <= req_pattern_length;
         hash_ff  <= hash_in;
         query_ff <= req_cmd;
         cur_ff   <= hash_in[AW-1:0];
      end else if (cmd.cur_from_link) begin
         cur_ff <= rd_ff[LNK_LO+AW-1:LNK_LO];
      end
      if (cmd.save_tail) begin
         tail_ff      <= rd_ff;
         tail_addr_ff <= cur_ff;
      end
      if (cmd.scan_init) begin
         scan_ff <= fss_ff;
      end else if (cmd.scan_next) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= res_slot_in;
      end
      if (cmd.rsp_push) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= slot_wide[SLOT_W-1:0];
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, res_slot_ff};

   // status back to the controller
   always_comb begin
      stat.clr_last     = (clr_ff == {AW{1'b1}});
      stat.req_bad      = req_bad_base || (req_pattern_length == '0) ||
                          (req_pattern_length > LEN_W'(MAX_BASES));
      stat.cmd_query    = query_ff;
      stat.rd_used      = rd_ff[WW-1];
      stat.rd_match     = (rd_ff[LNK_LO-1:HSH_LO] == hash_ff) &&
                          (rd_ff[HSH_LO-1:LEN_LO] == len_ff) &&
                          (rd_ff[LEN_LO-1:0] == key_ff);
      stat.rd_link_zero = (rd_ff[LNK_LO+AW-1:LNK_LO] == '0);
      stat.scan_end     = scan_ff[AW];
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

[rtl/dna_pattern_hash_registry_core.sv]
`timescale 1ns / 1ps
// An accepted request reads and checks its home slot, then responds; a bad base responds
// directly. Each chain hop repeats the read and check, each slot scanned for a free entry
// adds a scan read and check, and linking adds a tail write; one memory read per step.
// Throughput: one transaction at a time; the next is accepted once the result is staged.
// Reset: synchronous; a clearing pass zeroes each of the TABLE_SLOTS (4096 by default)
// entries of the slot store, with req_ready low until it ends.
module dna_pattern_hash_registry_core
   import dphr_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [KEY_W-1:0]    req_pattern_bases,
   input  logic [LEN_W-1:0]    req_pattern_length,
   input  logic                req_bad_base,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_index
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   dphr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dphr_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_pattern_bases  (req_pattern_bases),
      .req_pattern_length (req_pattern_length),
      .req_bad_base       (req_bad_base),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .cmd                (cmd),
      .stat               (stat)
   );

`ifndef ASSERT_OFF
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high during clearing pass");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while one is in flight");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_W'(ST_BAD)))
      else $error("undefined status code");
   a_no_slot_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STATUS_W'(ST_NOT_FOUND)) ||
                     (rsp_status == STATUS_W'(ST_FULL)) ||
                     (rsp_status == STATUS_W'(ST_BAD)))) |-> (rsp_slot_index == '0))
      else $error("slot index nonzero on a miss");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import dphr_pkg::*;

   localparam int SLOTS      = TABLE_SLOTS_DEF;
   localparam int CYCLE_CAP  = 1500000;
   localparam int DRAIN_WAIT = 40;

   typedef struct {
      status_type     status;
      logic [SLOT_W-1:0] slot;
   } registry_result_type;

   // Shadow copy of the pattern registry; predicts status and slot per transaction
   class registry_scoreboard;
      bit                used [SLOTS];
      bit [HASH_W-1:0]   hash_mem [SLOTS];
      bit [LEN_W-1:0]    len_mem [SLOTS];
      bit [KEY_W-1:0]    key_mem [SLOTS];
      int unsigned       link_mem [SLOTS];
      int unsigned       free_ptr;
      registry_result_type pending_q [$];
      int                mismatches;
      bit                full_seen;

      function new();
         foreach (used[i]) begin
            used[i] = 0;
            link_mem[i] = 0;
         end
         free_ptr = 1;
         mismatches = 0;
         full_seen = 0;
      endfunction

      function void push(status_type st, int unsigned slot);
         registry_result_type r;
         r.status = st;
         r.slot = slot[SLOT_W-1:0];
         if (st == ST_FULL) full_seen = 1;
         pending_q.push_back(r);
      endfunction

      // Walk the chain for one accepted request and record the expected answer
      function void note_request(bit cmd, bit [KEY_W-1:0] bases, bit [LEN_W-1:0] len, bit bad);
         bit [KEY_W-1:0]  key;
         bit [HASH_W-1:0] h32;
         bit [HASH_W-1:0] hash;
         int unsigned     h;
         int unsigned     j;
         int unsigned     steps;
         if (bad || len == 0 || len > MAX_BASES) begin
            push(ST_BAD, 0);
            return;
         end
         key = (len >= 32) ? bases : (bases & ((64'd1 << (2 * len)) - 64'd1));
         h32 = key[HASH_W-1:0];
         hash = h32 + (h32 >> 11) + (h32 >> 20);
         h = hash & (SLOTS - 1);
         if (!used[h]) begin
            if (cmd) begin
               push(ST_NOT_FOUND, 0);
               return;
            end
         end else begin
            for (steps = 0; steps < SLOTS; steps++) begin
               if (hash_mem[h] == hash && len_mem[h] == len && key_mem[h] == key) begin
                  push(cmd ? ST_FOUND : ST_DUPLICATE, h);
                  return;
               end
               if (link_mem[h] == 0) break;
               h = link_mem[h] & (SLOTS - 1);
               if (!used[h]) break;
            end
            if (cmd) begin
               push(ST_NOT_FOUND, 0);
               return;
            end
            if (used[h]) begin
               for (j = free_ptr; j < SLOTS; j++)
                  if (!used[j]) break;
               if (j >= SLOTS) begin
                  push(ST_FULL, 0);
                  return;
               end
               link_mem[h] = j;
               free_ptr = j + 1;
               h = j;
            end
         end
         used[h] = 1;
         hash_mem[h] = hash;
         len_mem[h] = len;
         key_mem[h] = key;
         push(ST_INSERTED, h);
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] slot);
         registry_result_type r;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d slot %0d", st, slot);
            return;
         end
         r = pending_q.pop_front();
         if (st !== r.status || slot !== r.slot) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                        r.status, r.slot, st, slot);
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic                req_cmd = 0;
   logic [KEY_W-1:0]    req_pattern_bases = '0;
   logic [LEN_W-1:0]    req_pattern_length = 1;
   logic                req_bad_base = 0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;

   registry_scoreboard sb = new();
   int unsigned        cycle_count = 0;
   bit [KEY_W-1:0]     pool_bases [$];
   bit [LEN_W-1:0]     pool_len [$];

   dna_pattern_hash_registry_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_pattern_bases(req_pattern_bases), .req_pattern_length(req_pattern_length),
      .req_bad_base(req_bad_base),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_slot_index(rsp_slot_index)
   );

   always #1 clock = ~clock;

   // Observe both handshakes and end the run on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready)
         sb.note_request(req_cmd, req_pattern_bases, req_pattern_length, req_bad_base);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_slot_index);
      if (cycle_count > CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stall the receiver in phases: always ready, random, mostly stalled
   always @(posedge clock) begin
      case ((cycle_count / 300) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(1, 0));
         default: rsp_ready <= ($urandom_range(3, 0) == 0);
      endcase
   end

   // Hold one transaction until accepted; call at a rising edge
   task automatic send(bit cmd, bit [KEY_W-1:0] bases, bit [LEN_W-1:0] len, bit bad);
      req_cmd <= cmd;
      req_pattern_bases <= bases;
      req_pattern_length <= len;
      req_bad_base <= bad;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!cmd && !bad && len >= 1 && len <= MAX_BASES && pool_bases.size() < 256) begin
         pool_bases.push_back(bases);
         pool_len.push_back(len);
      end
   endtask

   // Drop valid and wait, or keep streaming when n is zero
   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic burst_gap();
      if ($urandom_range(9, 0) < 3) pause($urandom_range(6, 1));
   endtask

   task automatic random_item();
      bit [KEY_W-1:0] b;
      bit [LEN_W-1:0] l;
      bit             c;
      int             pick;
      int             idx;
      pick = $urandom_range(99, 0);
      c = 1'($urandom_range(1, 0));
      b = {$urandom, $urandom};
      if (pick < 5) begin
         // malformed: bad flag or length outside 1..32
         l = LEN_W'($urandom_range(63, 0));
         send(c, b, l, (l >= 1 && l <= MAX_BASES) ? 1'b1 : 1'($urandom_range(1, 0)));
      end else if (pick < 50 && pool_bases.size() > 0) begin
         // revisit a stored pattern with fresh junk above its length
         idx = $urandom_range(pool_bases.size() - 1, 0);
         l = pool_len[idx];
         b = (l >= 32) ? pool_bases[idx]
             : ((pool_bases[idx] & ((64'd1 << (2 * l)) - 1)) | (b & ~((64'd1 << (2 * l)) - 1)));
         send(c, b, l, 1'b0);
      end else begin
         l = ($urandom_range(3, 0) == 0) ? LEN_W'($urandom_range(MAX_BASES, 1))
                                         : LEN_W'($urandom_range(8, 1));
         send(c, b, l, 1'b0);
      end
   endtask

   initial begin
      int n;
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, masking, collisions, malformed requests
      send(1'b1, 64'd0, 6'd1, 1'b0);
      send(1'b0, 64'd0, 6'd1, 1'b0);
      send(1'b0, 64'hFFFF_FFFF_FFFF_FFFC, 6'd1, 1'b0);
      send(1'b1, 64'hFFFF_FFFF_FFFF_FFFC, 6'd1, 1'b0);
      send(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0);
      send(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0);
      send(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0);
      send(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 6'd32, 1'b0);
      send(1'b0, 64'd2, 6'd32, 1'b0);
      send(1'b0, 64'd4096, 6'd32, 1'b0);
      send(1'b0, 64'h0000_0001_0000_1000, 6'd32, 1'b0);
      send(1'b1, 64'd4096, 6'd32, 1'b0);
      send(1'b1, 64'h0000_0001_0000_1000, 6'd32, 1'b0);
      send(1'b1, 64'd2, 6'd32, 1'b0);
      send(1'b1, 64'd2, 6'd31, 1'b0);
      send(1'b0, 64'd5, 6'd3, 1'b1);
      send(1'b1, 64'd5, 6'd3, 1'b1);
      send(1'b0, 64'd5, 6'd0, 1'b0);
      send(1'b0, 64'd5, 6'd33, 1'b0);
      send(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1);
      send(1'b0, 64'hAAAA_5555_0F0F_F0F0, 6'd20, 1'b0);
      send(1'b1, 64'h5555_AAAA_0F0F_F0F0, 6'd20, 1'b0);

      // Hold off until the block has answered everything
      pause(1);
      while (sb.pending_q.size() != 0) @(posedge clock);

      // Random bursts with random gaps
      for (n = 0; n < 1900; n++) begin
         random_item();
         if (n % 8 == 7) burst_gap();
      end

      // Insert a short run of sequential keys
      k = 0;
      while (!sb.full_seen && k < 24) begin
         send(1'b0, {32'h5A5A_5A5A, k[31:0]}, 6'd32, 1'b0);
         k++;
         if (k % 16 == 0) burst_gap();
      end
      send(1'b0, 64'h1234_5678_9ABC_DEF0, 6'd32, 1'b0);
      send(1'b1, {32'h5A5A_5A5A, 32'd7}, 6'd32, 1'b0);
      send(1'b1, 64'h0123_4567_89AB_CDEF, 6'd32, 1'b0);
      send(1'b0, 64'd0, 6'd1, 1'b0);
      pause(1);

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
